FILE: sv/cte_pkg.sv
// Shared types and constants for the cube texel to equirectangular address pipeline.
// No dependencies; imported by every module of the block.
package cte_pkg;

	localparam int QUO_BITS     = 17;
	localparam int ROOT_BITS    = 31;
	localparam int CORDIC_ITERS = 28;
	localparam int DW           = 18;
	localparam int CW           = 35;
	localparam int AW           = 35;
	localparam int LATENCY      = 1 + QUO_BITS + 3 + ROOT_BITS + CORDIC_ITERS + 1 + 4;

	typedef logic signed [DW-1:0] comp_t;
	typedef logic signed [CW-1:0] cvec_t;
	typedef logic signed [AW-1:0] angle_t;

	localparam comp_t  ONE_Q16   = 18'sd65536;
	localparam angle_t HALF_TURN = 35'sh0_8000_0000;

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_IMAGE_WIDTH  = 1'd0;
	localparam reg_idx_t REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [2:0] FACE_POS_X = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;

	typedef enum logic [1:0] {SRC_U, SRC_V, SRC_N} axis_src_t;

	typedef struct packed {
		axis_src_t src;
		logic      neg;
	} axis_t;

	typedef struct packed {
		axis_t dx;
		axis_t dy;
		axis_t dz;
	} face_map_t;

	// direction component sources per face; codes five and above act as -z
	function automatic face_map_t face_map(input logic [2:0] f);
		face_map_t m;
		case (f)
			FACE_POS_X: m = '{'{SRC_N, 1'b0}, '{SRC_V, 1'b1}, '{SRC_U, 1'b1}};
			FACE_NEG_X: m = '{'{SRC_N, 1'b1}, '{SRC_V, 1'b1}, '{SRC_U, 1'b0}};
			FACE_POS_Y: m = '{'{SRC_U, 1'b0}, '{SRC_N, 1'b0}, '{SRC_V, 1'b0}};
			FACE_NEG_Y: m = '{'{SRC_U, 1'b0}, '{SRC_N, 1'b1}, '{SRC_V, 1'b1}};
			FACE_POS_Z: m = '{'{SRC_U, 1'b0}, '{SRC_V, 1'b1}, '{SRC_N, 1'b0}};
			default:    m = '{'{SRC_U, 1'b1}, '{SRC_V, 1'b1}, '{SRC_N, 1'b1}};
		endcase
		return m;
	endfunction

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] t;
		case (i)
			5'd0:  t = 32'h20000000;
			5'd1:  t = 32'h12E4051E;
			5'd2:  t = 32'h09FB385B;
			5'd3:  t = 32'h051111D4;
			5'd4:  t = 32'h028B0D43;
			5'd5:  t = 32'h0145D7E1;
			5'd6:  t = 32'h00A2F61E;
			5'd7:  t = 32'h00517C55;
			5'd8:  t = 32'h0028BE53;
			5'd9:  t = 32'h00145F2F;
			5'd10: t = 32'h000A2F98;
			5'd11: t = 32'h000517CC;
			5'd12: t = 32'h00028BE6;
			5'd13: t = 32'h000145F3;
			5'd14: t = 32'h0000A2FA;
			5'd15: t = 32'h0000517D;
			5'd16: t = 32'h000028BE;
			5'd17: t = 32'h0000145F;
			5'd18: t = 32'h00000A30;
			5'd19: t = 32'h00000518;
			5'd20: t = 32'h0000028C;
			5'd21: t = 32'h00000146;
			5'd22: t = 32'h000000A3;
			5'd23: t = 32'h00000051;
			5'd24: t = 32'h00000029;
			5'd25: t = 32'h00000014;
			5'd26: t = 32'h0000000A;
			5'd27: t = 32'h00000005;
			5'd28: t = 32'h00000003;
			5'd29: t = 32'h00000001;
			5'd30: t = 32'h00000001;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction

endpackage

FILE: sv/cte_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on cte_pkg.
module cte_div #(
	parameter int FS_W = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [FS_W:0]                  num_a,
	input  logic [FS_W:0]                  num_b,
	input  logic [FS_W-1:0]                den,
	output logic                           out_valid,
	output logic [cte_pkg::QUO_BITS-1:0]   quo_a,
	output logic [cte_pkg::QUO_BITS-1:0]   quo_b
);
	import cte_pkg::*;

	localparam int RW = FS_W + 1;

	logic [RW-1:0]       ra_s [QUO_BITS];
	logic [RW-1:0]       rb_s [QUO_BITS];
	logic [QUO_BITS-1:0] qa_s [QUO_BITS];
	logic [QUO_BITS-1:0] qb_s [QUO_BITS];
	logic                v_s  [QUO_BITS];

	genvar g;
	for (g = 0; g < QUO_BITS; g++) begin : g_step
		logic [RW-1:0]       ra_in, rb_in;
		logic [QUO_BITS-1:0] qa_in, qb_in;
		logic                v_in, ge_a, ge_b;

		if (g == 0) begin : g_first
			assign ra_in = num_a;
			assign rb_in = num_b;
			assign qa_in = '0;
			assign qb_in = '0;
			assign v_in  = in_valid;
		end else begin : g_next
			assign ra_in = {ra_s[g-1][RW-2:0], 1'b0};
			assign rb_in = {rb_s[g-1][RW-2:0], 1'b0};
			assign qa_in = qa_s[g-1];
			assign qb_in = qb_s[g-1];
			assign v_in  = v_s[g-1];
		end

		assign ge_a = ra_in >= RW'(den);
		assign ge_b = rb_in >= RW'(den);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else begin
				v_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			ra_s[g] <= ge_a ? ra_in - RW'(den) : ra_in;
			rb_s[g] <= ge_b ? rb_in - RW'(den) : rb_in;
			qa_s[g] <= {qa_in[QUO_BITS-2:0], ge_a};
			qb_s[g] <= {qb_in[QUO_BITS-2:0], ge_b};
		end
	end

	assign out_valid = v_s[QUO_BITS-1];
	assign quo_a     = qa_s[QUO_BITS-1];
	assign quo_b     = qb_s[QUO_BITS-1];

endmodule

FILE: sv/cte_isqrt.sv
// Pipelined floor integer square root, one root bit per stage, with a side tag.
// Depends on cte_pkg.
module cte_isqrt #(
	parameter int RB    = 31,
	parameter int TAG_W = 54
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2*RB-1:0]   rad,
	input  logic [TAG_W-1:0]  tag_in,
	output logic              out_valid,
	output logic [RB-1:0]     root,
	output logic [TAG_W-1:0]  tag_out
);
	import cte_pkg::*;

	logic [RB:0]      rem_s  [RB];
	logic [RB-1:0]    root_s [RB];
	logic [2*RB-1:0]  rad_s  [RB];
	logic [TAG_W-1:0] tag_s  [RB];
	logic             v_s    [RB];

	genvar g;
	for (g = 0; g < RB; g++) begin : g_step
		logic [RB:0]      rem_p;
		logic [RB-1:0]    root_p;
		logic [2*RB-1:0]  rad_p;
		logic [TAG_W-1:0] tag_p;
		logic             v_p, ge;
		logic [RB+1:0]    rin, trial, diff;

		if (g == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
			assign tag_p  = tag_in;
			assign v_p    = in_valid;
		end else begin : g_next
			assign rem_p  = rem_s[g-1];
			assign root_p = root_s[g-1];
			assign rad_p  = rad_s[g-1];
			assign tag_p  = tag_s[g-1];
			assign v_p    = v_s[g-1];
		end

		assign rin   = {rem_p[RB-1:0], rad_p[2*RB-1 -: 2]};
		assign trial = {root_p, 2'b01};
		assign ge    = rin >= trial;
		assign diff  = rin - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else begin
				v_s[g] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g]  <= ge ? diff[RB:0] : rin[RB:0];
			root_s[g] <= {root_p[RB-2:0], ge};
			rad_s[g]  <= {rad_p[2*RB-3:0], 2'b00};
			tag_s[g]  <= tag_p;
		end
	end

	assign out_valid = v_s[RB-1];
	assign root      = root_s[RB-1];
	assign tag_out   = tag_s[RB-1];

endmodule

FILE: sv/cte_cordic.sv
// Pipelined vectoring CORDIC atan2 in turn units: a pre-rotation stage, then one
// stage per iteration. Depends on cte_pkg.
module cte_cordic (
	input  logic            clk,
	input  cte_pkg::cvec_t  x_in,
	input  cte_pkg::cvec_t  y_in,
	output cte_pkg::angle_t ang
);
	import cte_pkg::*;

	localparam int NS = CORDIC_ITERS + 1;

	cvec_t  x_s [NS];
	cvec_t  y_s [NS];
	angle_t a_s [NS];
	logic   z_s [NS];

	always_ff @(posedge clk) begin
		z_s[0] <= (x_in == '0) && (y_in == '0);
		if (x_in < 0) begin
			x_s[0] <= -x_in;
			y_s[0] <= -y_in;
			a_s[0] <= (y_in >= 0) ? HALF_TURN : -HALF_TURN;
		end else begin
			x_s[0] <= x_in;
			y_s[0] <= y_in;
			a_s[0] <= '0;
		end
	end

	genvar g;
	for (g = 0; g < CORDIC_ITERS; g++) begin : g_iter
		cvec_t  dx, dy;
		angle_t t;

		assign dx = x_s[g] >>> g;
		assign dy = y_s[g] >>> g;
		assign t  = AW'(atan_turn(5'(g)));

		always_ff @(posedge clk) begin
			z_s[g+1] <= z_s[g];
			if (y_s[g] > 0) begin
				x_s[g+1] <= x_s[g] + dy;
				y_s[g+1] <= y_s[g] - dx;
				a_s[g+1] <= a_s[g] + t;
			end else begin
				x_s[g+1] <= x_s[g] - dy;
				y_s[g+1] <= y_s[g] + dx;
				a_s[g+1] <= a_s[g] - t;
			end
		end
	end

	always_comb begin
		if (z_s[NS-1]) begin
			ang = '0;
		end else if (a_s[NS-1] > HALF_TURN) begin
			ang = HALF_TURN;
		end else if (a_s[NS-1] < -HALF_TURN) begin
			ang = -HALF_TURN;
		end else begin
			ang = a_s[NS-1];
		end
	end

endmodule

FILE: sv/cubemap_texel_to_equirect_addr.sv
// One texel accepted every cycle; busy stays low.
// Depth is set by the 17-stage divider, the 31-stage square root and the 29-stage CORDIC.
// Results appear for one cycle on done and cannot be held off.
// Reset clears all valid bits and loads width 4096, height 2048.
// Top level: cube face texel to equirectangular source address.
// Depends on cte_pkg, cte_div, cte_isqrt, cte_cordic.
module cubemap_texel_to_equirect_addr #(
	parameter int MAX_WIDTH  = 8192,
	parameter int ANGLE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        face,
	input  logic [10:0]       col,
	input  logic [10:0]       row,
	input  logic              cfg_wr_en,
	input  cte_pkg::reg_idx_t cfg_index,
	input  logic [13:0]       cfg_data,
	output logic              done,
	output logic [12:0]       src_x,
	output logic [12:0]       src_y,
	output logic [25:0]       src_index
);
	import cte_pkg::*;

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int FS_W = WW - 2;
	localparam int KW   = (FS_W > 11) ? FS_W : 11;
	localparam int CMPW = (WW > 14) ? WW : 14;
	localparam int LW   = AW + 2;
	localparam int FW   = ANGLE_BITS + 1;
	localparam int PW   = FW + WW;
	localparam int IW   = 2 * WW + 1;
	localparam logic signed [LW-1:0] FULL_L = $signed(LW'(33'h1_0000_0000));

	logic [13:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 14'd4096;
			height_q <= 14'd2048;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CMPW-1:0] w_ext, h_ext;
	logic [WW-1:0]   w_cl, h_cl;
	logic [FS_W-1:0] fs, fs_m1, k_c, l_c;

	assign w_ext = CMPW'(width_q);
	assign h_ext = CMPW'(height_q);

	always_comb begin
		if (w_ext < CMPW'(4)) begin
			w_cl = WW'(4);
		end else if (w_ext > CMPW'(MAX_WIDTH)) begin
			w_cl = WW'(MAX_WIDTH);
		end else begin
			w_cl = WW'(w_ext);
		end
		if (h_ext < CMPW'(1)) begin
			h_cl = WW'(1);
		end else if (h_ext > CMPW'(MAX_WIDTH)) begin
			h_cl = WW'(MAX_WIDTH);
		end else begin
			h_cl = WW'(h_ext);
		end
	end

	assign fs    = w_cl[WW-1:2];
	assign fs_m1 = fs - FS_W'(1);
	assign k_c   = (KW'(col) > KW'(fs_m1)) ? fs_m1 : FS_W'(col);
	assign l_c   = (KW'(row) > KW'(fs_m1)) ? fs_m1 : FS_W'(row);

	assign busy = 1'b0;

	// stage 1: clamp texel, form 2k+1
	logic          v_s1;
	logic [2:0]    face_s1;
	logic [FS_W:0] numk_s1, numl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		face_s1 <= face;
		numk_s1 <= {k_c, 1'b1};
		numl_s1 <= {l_c, 1'b1};
	end

	logic                v_dq;
	logic [QUO_BITS-1:0] qu, qv;
	logic [2:0]          face_dq [QUO_BITS];

	cte_div #(.FS_W(FS_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.num_a     (numk_s1),
		.num_b     (numl_s1),
		.den       (fs),
		.out_valid (v_dq),
		.quo_a     (qu),
		.quo_b     (qv)
	);

	always_ff @(posedge clk) begin
		face_dq[0] <= face_s1;
		for (int i = 1; i < QUO_BITS; i++) begin
			face_dq[i] <= face_dq[i-1];
		end
	end

	// stage 2: direction vector
	function automatic comp_t pick(input axis_t a, input comp_t u, input comp_t v);
		comp_t val;
		case (a.src)
			SRC_U:   val = u;
			SRC_V:   val = v;
			default: val = ONE_Q16;
		endcase
		return a.neg ? -val : val;
	endfunction

	comp_t     u_c, v_c;
	face_map_t fm;
	logic      v_s2, v_s3, v_s4;
	comp_t     dx_s2, dy_s2, dz_s2, dx_s3, dy_s3, dz_s3, dx_s4, dy_s4, dz_s4;
	logic [32:0] sqx_s3, sqz_s3;
	logic [33:0] sum_s4;
	logic signed [2*DW-1:0] px2, pz2;

	assign u_c = $signed({1'b0, qu}) - ONE_Q16;
	assign v_c = $signed({1'b0, qv}) - ONE_Q16;
	assign fm  = face_map(face_dq[QUO_BITS-1]);
	assign px2 = dx_s2 * dx_s2;
	assign pz2 = dz_s2 * dz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= v_dq;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= pick(fm.dx, u_c, v_c);
		dy_s2  <= pick(fm.dy, u_c, v_c);
		dz_s2  <= pick(fm.dz, u_c, v_c);
		sqx_s3 <= px2[32:0];
		sqz_s3 <= pz2[32:0];
		dx_s3  <= dx_s2;
		dy_s3  <= dy_s2;
		dz_s3  <= dz_s2;
		sum_s4 <= {1'b0, sqx_s3} + {1'b0, sqz_s3};
		dx_s4  <= dx_s3;
		dy_s4  <= dy_s3;
		dz_s4  <= dz_s3;
	end

	// horizontal radius, scaled by 2^14
	logic                   v_r;
	logic [ROOT_BITS-1:0]   root;
	logic [3*DW-1:0]        tag_r;
	comp_t                  dx_r, dy_r, dz_r;

	cte_isqrt #(.RB(ROOT_BITS), .TAG_W(3*DW)) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.rad       ({sum_s4, 28'd0}),
		.tag_in    ({dx_s4, dy_s4, dz_s4}),
		.out_valid (v_r),
		.root      (root),
		.tag_out   (tag_r)
	);

	assign dx_r = $signed(tag_r[3*DW-1:2*DW]);
	assign dy_r = $signed(tag_r[2*DW-1:DW]);
	assign dz_r = $signed(tag_r[DW-1:0]);

	cvec_t  lon_x, lon_y, lat_x, lat_y;
	angle_t lon_ang, lat_ang;

	assign lon_x = CW'(dx_r) <<< 14;
	assign lon_y = CW'(dz_r) <<< 14;
	assign lat_x = $signed(CW'(root));
	assign lat_y = CW'(dy_r) <<< 14;

	cte_cordic u_cordic_lon (.clk(clk), .x_in(lon_x), .y_in(lon_y), .ang(lon_ang));
	cte_cordic u_cordic_lat (.clk(clk), .x_in(lat_x), .y_in(lat_y), .ang(lat_ang));

	logic v_c_s [CORDIC_ITERS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= CORDIC_ITERS; i++) begin
				v_c_s[i] <= 1'b0;
			end
		end else begin
			v_c_s[0] <= v_r;
			for (int i = 1; i <= CORDIC_ITERS; i++) begin
				v_c_s[i] <= v_c_s[i-1];
			end
		end
	end

	// stage 5..8: turn fraction, scale, linear index
	function automatic logic [FW-1:0] to_fraction(input logic signed [LW-1:0] l);
		logic [32:0] lc, lr;
		if (l < 0) begin
			lc = '0;
		end else if (l > FULL_L) begin
			lc = 33'h1_0000_0000;
		end else begin
			lc = l[32:0];
		end
		lr = lc + (33'd1 << (31 - ANGLE_BITS));
		return lr[32 -: FW];
	endfunction

	logic signed [LW-1:0] l_lon, l_lat;
	logic          v_s5, v_s6, v_s7, v_s8;
	logic [FW-1:0] fx_s5, fy_s5;
	logic [PW-1:0] px_s6, py_s6;
	logic [WW-1:0] sx_s7, sy_s7;
	logic [12:0]   src_x_s8, src_y_s8;
	logic [25:0]   src_index_s8;
	logic [IW-1:0] idx;

	assign l_lon = LW'(lon_ang) + LW'(HALF_TURN);
	assign l_lat = (LW'(lat_ang) <<< 1) + LW'(HALF_TURN);
	assign idx   = IW'(sy_s7) * IW'(w_cl) + IW'(sx_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s5 <= v_c_s[CORDIC_ITERS];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		fx_s5        <= to_fraction(l_lon);
		fy_s5        <= to_fraction(l_lat);
		px_s6        <= PW'(fx_s5) * PW'(w_cl - WW'(1));
		py_s6        <= PW'(fy_s5) * PW'(h_cl - WW'(1));
		sx_s7        <= px_s6[ANGLE_BITS +: WW];
		sy_s7        <= py_s6[ANGLE_BITS +: WW];
		src_x_s8     <= 13'(sx_s7);
		src_y_s8     <= 13'(sy_s7);
		src_index_s8 <= 26'(idx);
	end

	assign done      = v_s8;
	assign src_x     = src_x_s8;
	assign src_y     = src_y_s8;
	assign src_index = src_index_s8;

endmodule

FILE: sv/cte_chk.sv
// Port-level checker for the texel address pipeline, bound to the top level.
// Depends on cte_pkg and cubemap_texel_to_equirect_addr.
module cte_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import cte_pkg::*;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("transfer accepted without result after fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching input transfer");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !done)
		else $error("result strobe during reset");

endmodule

bind cubemap_texel_to_equirect_addr cte_chk u_cte_chk (.*);

FILE: sim/cubemap_texel_to_equirect_addr_tb.sv
// Testbench for cubemap_texel_to_equirect_addr: random and directed texels over several
// panorama sizes, checked against a bit-exact predictor of the fixed-point mapping.
// Depends on cte_pkg and the block's RTL.
`timescale 1ns / 100ps

module cubemap_texel_to_equirect_addr_tb;
	import cte_pkg::*;

	typedef struct {
		logic [2:0]  face;
		logic [10:0] col;
		logic [10:0] row;
	} texel_t;

	typedef struct {
		logic [12:0] x;
		logic [12:0] y;
		logic [25:0] idx;
	} addr_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  face = '0;
	logic [10:0] col = '0;
	logic [10:0] row = '0;
	logic        cfg_wr_en = 1'b0;
	reg_idx_t    cfg_index = REG_IMAGE_WIDTH;
	logic [13:0] cfg_data = '0;
	logic        done;
	logic [12:0] src_x;
	logic [12:0] src_y;
	logic [25:0] src_index;

	cubemap_texel_to_equirect_addr dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.face(face), .col(col), .row(row),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .src_x(src_x), .src_y(src_y), .src_index(src_index)
	);

	texel_t pending_texels[$];
	addr_t  expected_addrs[$];
	int     errors = 0;
	int     idle_left = 0;
	bit     steady = 1'b0;
	logic [13:0] cur_width = 14'd4096;
	logic [13:0] cur_height = 14'd2048;

	localparam longint HALF = 64'sd2147483648;
	localparam longint ANG_TAB[32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	function automatic longint vec_angle(longint y, longint x);
		longint a, sx, sy;
		a = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			a = (y >= 0) ? HALF : -HALF;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 28; i++) begin
			sx = x >>> i;
			sy = y >>> i;
			if (y > 0) begin
				x = x + sy;
				y = y - sx;
				a = a + ANG_TAB[i];
			end else begin
				x = x - sy;
				y = y + sx;
				a = a - ANG_TAB[i];
			end
		end
		if (a > HALF)
			a = HALF;
		if (a < -HALF)
			a = -HALF;
		return a;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned a);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > a)
			b = b >> 2;
		while (b != 0) begin
			if (a >= res + b) begin
				a = a - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned turn_to_pixel(longint l, longint unsigned size);
		longint unsigned f;
		if (l < 0)
			l = 0;
		if (l > 2 * HALF)
			l = 2 * HALF;
		f = (longint'(l) + (64'd1 << 15)) >> 16;
		return (f * (size - 1)) >> 16;
	endfunction

	function automatic addr_t source_addr(texel_t t);
		longint unsigned w, h, fs, k, l, sx, sy, rr;
		longint u, v, n, dx, dy, dz, lon, lat, r;
		int f;
		addr_t res;
		w = cur_width;
		h = cur_height;
		if (w < 4) w = 4;
		if (w > 8192) w = 8192;
		if (h < 1) h = 1;
		if (h > 8192) h = 8192;
		fs = w >> 2;
		f = t.face;
		if (f > 5) f = 5;
		k = t.col;
		l = t.row;
		if (k > fs - 1) k = fs - 1;
		if (l > fs - 1) l = fs - 1;
		u = longint'(((2 * k + 1) << 16) / fs) - 65536;
		v = longint'(((2 * l + 1) << 16) / fs) - 65536;
		n = 65536;
		case (f)
			0: begin dx = n;  dy = -v; dz = -u; end
			1: begin dx = -n; dy = -v; dz = u;  end
			2: begin dx = u;  dy = n;  dz = v;  end
			3: begin dx = u;  dy = -n; dz = -v; end
			4: begin dx = u;  dy = -v; dz = n;  end
			default: begin dx = -u; dy = -v; dz = -n; end
		endcase
		lon = vec_angle(dz * 16384, dx * 16384);
		rr = longint'(dx * dx + dz * dz) << 28;
		r = longint'(root_floor(rr));
		lat = vec_angle(dy * 16384, r);
		sx = turn_to_pixel(lon + HALF, w);
		sy = turn_to_pixel(2 * lat + HALF, h);
		res.x = sx[12:0];
		res.y = sy[12:0];
		res.idx = 26'(sy * w + sx);
		return res;
	endfunction

	initial forever #10 clk = ~clk;

	// driver
	always @(posedge clk or negedge arst_n) begin
		texel_t t;
		if (!arst_n) begin
			start <= 1'b0;
			idle_left = 0;
		end else begin
			if (start && !busy) begin
				t.face = face;
				t.col = col;
				t.row = row;
				expected_addrs.push_back(source_addr(t));
			end
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (pending_texels.size() != 0) begin
					if (!steady && $urandom_range(0, 5) == 0) begin
						idle_left = $urandom_range(1, 3) - 1;
						start <= 1'b0;
					end else begin
						t = pending_texels.pop_front();
						start <= 1'b1;
						face <= t.face;
						col <= t.col;
						row <= t.row;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		addr_t e;
		if (arst_n && done) begin
			if (expected_addrs.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				e = expected_addrs.pop_front();
				if (src_x !== e.x) begin
					$error("src_x expected %0d actual %0d", e.x, src_x);
					errors++;
				end
				if (src_y !== e.y) begin
					$error("src_y expected %0d actual %0d", e.y, src_y);
					errors++;
				end
				if (src_index !== e.idx) begin
					$error("src_index expected %0d actual %0d", e.idx, src_index);
					errors++;
				end
			end
		end
	end

	task automatic set_size(input logic [13:0] w, input logic [13:0] h);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_width = w;
		cur_height = h;
	endtask

	task automatic drain;
		do begin
			@(posedge clk);
			#1;
		end while (pending_texels.size() != 0 || start || expected_addrs.size() != 0);
	endtask

	task automatic queue_texel(input int f, input int c, input int r);
		texel_t t;
		t.face = 3'(f);
		t.col = 11'(c);
		t.row = 11'(r);
		pending_texels.push_back(t);
	endtask

	task automatic queue_random(input int count);
		int fs, w;
		w = (cur_width < 4) ? 4 : (cur_width > 8192) ? 8192 : cur_width;
		fs = w / 4;
		for (int i = 0; i < count; i++) begin
			queue_texel($urandom_range(0, 7),
				($urandom_range(0, 3) != 0) ? $urandom_range(0, fs - 1) : $urandom_range(0, 2047),
				($urandom_range(0, 3) != 0) ? $urandom_range(0, fs - 1) : $urandom_range(0, 2047));
		end
	endtask

	initial begin
		logic [13:0] widths[7] = '{14'd4, 14'd16383, 14'd0, 14'd20, 14'd8192, 14'd2048, 14'd44};
		logic [13:0] heights[7] = '{14'd1, 14'd16383, 14'd0, 14'd7, 14'd8192, 14'd3, 14'd1000};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// reset sizes: face corners and out-of-face texels
		for (int f = 0; f < 8; f++) begin
			queue_texel(f, 0, 0);
			queue_texel(f, 2047, 0);
			queue_texel(f, 0, 2047);
		end
		queue_random(130);
		drain();
		for (int p = 0; p < 7; p++) begin
			set_size(widths[p], heights[p]);
			if (widths[p] == 14'd20) begin
				// odd face size: y faces hit the zero vector at the centre
				queue_texel(2, 2, 2);
				queue_texel(3, 2, 2);
			end
			queue_random(150);
			drain();
		end
		set_size(14'($urandom_range(4, 8192)), 14'($urandom_range(1, 8192)));
		steady = 1'b1;
		queue_random(100);
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_addrs.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
